// ===== rtl/signed_integer_to_decimal_text_core_defines.svh =====
// Assertion macros shared by the decimal text converter RTL.
`ifndef SIGNED_INTEGER_TO_DECIMAL_TEXT_CORE_DEFINES_SVH
`define SIGNED_INTEGER_TO_DECIMAL_TEXT_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define SITDT_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define SITDT_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sitdt_pkg.sv =====
// ----------------------------------------------------------------------------
// sitdt_pkg
// Types and constants shared by the signed integer to decimal text converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sitdt_pkg;

  localparam int VALUE_W     = 32;
  localparam int CHAR_W      = 8;
  localparam int NUM_DIGITS  = 10;
  localparam int BCD_W       = 4 * NUM_DIGITS;
  localparam int DIGIT_IDX_W = 4;
  localparam int STEP_W      = 5;
  localparam int NUM_STEPS   = VALUE_W;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_SCAN,
    ST_SIGN,
    ST_DIGITS
  } state_t;

  typedef struct packed {
    logic load;
    logic shift;
    logic scan;
    logic put_sign;
    logic put_digit;
  } cmd_t;

  typedef struct packed {
    logic step_done;
    logic negative;
    logic digit_last;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/sitdt_if.sv =====
// ----------------------------------------------------------------------------
// sitdt_if
// Valid/ready channels for the input number and the output characters.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sitdt_value_if import sitdt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

interface sitdt_char_if import sitdt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              last;

  modport source (output valid, output character, output last, input ready);
  modport sink (input valid, input character, input last, output ready);
endinterface

// ===== rtl/sitdt_dpath.sv =====
// ----------------------------------------------------------------------------
// sitdt_dpath
// Magnitude, shift-add-3 BCD register, digit pointer and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "signed_integer_to_decimal_text_core_defines.svh"

module sitdt_dpath import sitdt_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic [VALUE_W-1:0] in_value,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [CHAR_W-1:0]  out_character,
  output logic               out_last
);

  logic [VALUE_W-1:0]     mag;
  logic [BCD_W-1:0]       bcd;
  logic                   negative;
  logic [STEP_W-1:0]      step;
  logic [DIGIT_IDX_W-1:0] digit_idx;
  logic [BCD_W-1:0]       bcd_adj;
  logic [DIGIT_IDX_W-1:0] lead_idx;
  logic [3:0]             cur_digit;

  // Add 3 to every BCD digit of 5 or more before the left shift.
  always_comb begin
    logic [3:0] nib;
    nib = '0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      nib = bcd[i*4 +: 4];
      bcd_adj[i*4 +: 4] = (nib >= 4'd5) ? nib + 4'd3 : nib;
    end
  end

  // Highest nonzero digit; zero gives the units digit so "0" is still printed.
  always_comb begin
    lead_idx = '0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd[i*4 +: 4] != 4'd0) begin
        lead_idx = DIGIT_IDX_W'(i);
      end
    end
  end

  assign cur_digit = bcd[digit_idx*4 +: 4];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      negative <= in_value[VALUE_W-1];
      mag      <= in_value[VALUE_W-1] ? (~in_value + VALUE_W'(1)) : in_value;
      bcd      <= '0;
      step     <= '0;
    end else if (cmd.shift) begin
      mag  <= {mag[VALUE_W-2:0], 1'b0};
      bcd  <= {bcd_adj[BCD_W-2:0], mag[VALUE_W-1]};
      step <= step + STEP_W'(1);
    end
    if (cmd.scan) begin
      digit_idx <= lead_idx;
    end else if (cmd.put_digit) begin
      digit_idx <= digit_idx - DIGIT_IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.put_sign || cmd.put_digit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.put_sign) begin
      out_character <= CHAR_MINUS;
      out_last      <= 1'b0;
    end else if (cmd.put_digit) begin
      out_character <= CHAR_ZERO + {4'd0, cur_digit};
      out_last      <= (digit_idx == '0);
    end
  end

  assign sts.step_done  = (step == STEP_W'(NUM_STEPS - 1));
  assign sts.negative   = negative;
  assign sts.digit_last = (digit_idx == '0);
  assign sts.out_free   = !out_valid || out_ready;

  `SITDT_ASSERT_NEXT(a_lead_in_range, clk, rst, cmd.scan, digit_idx < DIGIT_IDX_W'(NUM_DIGITS), "leading digit index out of range")
  `SITDT_ASSERT_NOW(a_put_needs_slot, clk, rst, cmd.put_sign || cmd.put_digit, !out_valid || out_ready, "character loaded over a beat not yet taken")

endmodule

// ===== rtl/sitdt_ctrl.sv =====
// ----------------------------------------------------------------------------
// sitdt_ctrl
// Sequencer: accept, 32 conversion steps, leading digit scan, emit text.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "signed_integer_to_decimal_text_core_defines.svh"

module sitdt_ctrl import sitdt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_CONVERT;
        end
      end
      ST_CONVERT: begin
        cmd.shift = 1'b1;
        if (sts.step_done) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan   = 1'b1;
        state_next = sts.negative ? ST_SIGN : ST_DIGITS;
      end
      ST_SIGN: begin
        if (sts.out_free) begin
          cmd.put_sign = 1'b1;
          state_next   = ST_DIGITS;
        end
      end
      ST_DIGITS: begin
        if (sts.out_free) begin
          cmd.put_digit = 1'b1;
          if (sts.digit_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `SITDT_ASSERT_NEXT(a_accept_starts, clk, rst, in_valid && in_ready, state == ST_CONVERT, "accepted number did not start conversion")
  `SITDT_ASSERT_NEXT(a_convert_ends, clk, rst, state == ST_CONVERT && sts.step_done, state == ST_SCAN, "conversion did not end after the last step")
  `SITDT_ASSERT_NEXT(a_last_digit_idle, clk, rst, cmd.put_digit && sts.digit_last, state == ST_IDLE, "sequencer kept going after the last digit")

endmodule

// ===== rtl/signed_integer_to_decimal_text_core.sv =====
// ----------------------------------------------------------------------------
// signed_integer_to_decimal_text_core
// Converts a signed 32-bit integer to decimal ASCII, one character per beat.
// ----------------------------------------------------------------------------
//   channel  dir  payload              beat
//   number   in   value[31:0] signed   one integer
//   text     out  character[7:0], last one character, last on the final one
//
// A number takes an accept step, 32 shift-add-3 steps in the BCD register,
// a leading digit scan and then the emission of its 1 to 11 characters.
// The shift-add-3 loop is the longest phase when the output never stalls.
// A new number is taken once the final character sits in the output register.
// Output stalls hold the sequencer; rst is synchronous and clears control only.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module signed_integer_to_decimal_text_core import sitdt_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  sitdt_value_if.sink   number,
  sitdt_char_if.source  text
);

  cmd_t cmd;
  sts_t sts;

  sitdt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (number.valid),
    .in_ready (number.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sitdt_dpath u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .in_value      (number.value),
    .out_ready     (text.ready),
    .out_valid     (text.valid),
    .out_character (text.character),
    .out_last      (text.last)
  );

endmodule
